/* rtl/core/vna_pkg.sv */
package vna_pkg;

  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned MAX_INDICES  = 4096;
  localparam int unsigned VA_W         = $clog2(MAX_VERTICES);  // vertex address
  localparam int unsigned IA_W         = $clog2(MAX_INDICES);   // index address
  localparam int unsigned VC_W         = 11;                    // vertex_count
  localparam int unsigned IC_W         = 13;                    // index_count
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned CR_W         = 35;                    // one cross product term
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 13;

  // input word function codes
  typedef enum logic [1:0] {
    FUNC_WR_POS    = 2'd0,
    FUNC_WR_IDX    = 2'd1,
    FUNC_COMPUTE   = 2'd2,
    FUNC_RD_NORMAL = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_INDEX_COUNT  = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [9:0]         index_value;
  } vna_in_t;

  typedef struct packed {
    logic [9:0]         vertex_slot;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               is_done;
    logic               index_fault;
  } vna_out_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR,
    OP_TRI_INIT,
    OP_SEQ_V,
    OP_IDX_RD,
    OP_SKIP,
    OP_POS_RD,
    OP_EDGE,
    OP_MUL,
    OP_SUM_RD,
    OP_SUM_WR,
    OP_NEXT,
    OP_EMIT_DONE,
    OP_RD_SLOT,
    OP_MAG,
    OP_SHIFT,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_EMIT_RD
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_CLR,
    ST_TRI_INIT,
    ST_TRI,
    ST_IDX,
    ST_CHECK,
    ST_POS,
    ST_EDGE,
    ST_MUL,
    ST_SRD,
    ST_SWR,
    ST_NEXT,
    ST_DONE,
    ST_RSEL,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] lane;
  } vna_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic tri_more;
    logic indexed;
    logic vfault;
    logic slot_oob;
    logic zero;
    logic big;
    logic sqrt_busy;
    logic div_last;
  } vna_stat_t;

endpackage

/* rtl/core/vna_ctrl.sv */
module vna_ctrl import vna_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  func_i,
  input  vna_stat_t   stat_i,
  output vna_cmd_t    cmd_o,
  output logic        busy_o
);

  ctl_state_e state_q, state_d;
  logic [2:0] lane_q, lane_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_CLR;
      lane_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    unique case (state_q)
      ST_INIT_CLR: if (stat_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        lane_d = 3'd0;
        if (start_i) begin
          unique case (func_i)
            FUNC_COMPUTE:   state_d = ST_CLR;
            FUNC_RD_NORMAL: state_d = ST_RSEL;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLR:      if (stat_i.clr_last) state_d = ST_TRI_INIT;
      ST_TRI_INIT: state_d = ST_TRI;
      ST_TRI: begin
        lane_d = 3'd0;
        if (!stat_i.tri_more)    state_d = ST_DONE;
        else if (stat_i.indexed) state_d = ST_IDX;
        else                     state_d = ST_POS;
      end
      ST_IDX: begin
        lane_d = lane_q + 3'd1;
        if (lane_q == 3'd3) begin
          lane_d  = 3'd0;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = stat_i.vfault ? ST_TRI : ST_POS;
      ST_POS: begin
        lane_d = lane_q + 3'd1;
        if (lane_q == 3'd3) begin
          lane_d  = 3'd0;
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: state_d = ST_MUL;
      ST_MUL: begin
        lane_d = lane_q + 3'd1;
        if (lane_q == 3'd6) begin
          lane_d  = 3'd0;
          state_d = ST_SRD;
        end
      end
      ST_SRD: state_d = ST_SWR;
      ST_SWR: begin
        lane_d  = lane_q + 3'd1;
        state_d = ST_SRD;
        if (lane_q == 3'd2) begin
          lane_d  = 3'd0;
          state_d = ST_NEXT;
        end
      end
      ST_NEXT:  state_d = ST_TRI;
      ST_DONE:  state_d = ST_IDLE;
      ST_RSEL:  state_d = stat_i.slot_oob ? ST_EMIT : ST_MAG;
      ST_MAG:   state_d = ST_SHIFT;
      ST_SHIFT: begin
        lane_d = 3'd0;
        if (stat_i.zero)     state_d = ST_EMIT;
        else if (!stat_i.big) state_d = ST_SQ;
      end
      ST_SQ: begin
        lane_d = lane_q + 3'd1;
        if (lane_q == 3'd3) begin
          lane_d  = 3'd0;
          state_d = ST_SQRT_INIT;
        end
      end
      ST_SQRT_INIT: state_d = ST_SQRT;
      ST_SQRT:      if (!stat_i.sqrt_busy) state_d = ST_DIV_INIT;
      ST_DIV_INIT:  state_d = ST_DIV;
      ST_DIV:       if (stat_i.div_last) state_d = ST_DIV_END;
      ST_DIV_END: begin
        lane_d  = lane_q + 3'd1;
        state_d = ST_DIV_INIT;
        if (lane_q == 3'd2) state_d = ST_EMIT;
      end
      ST_EMIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.lane = lane_q;
    unique case (state_q)
      ST_INIT_CLR, ST_CLR: cmd_o.op = OP_CLR;
      ST_IDLE:      if (start_i) cmd_o.op = OP_ACCEPT;
      ST_TRI_INIT:  cmd_o.op = OP_TRI_INIT;
      ST_TRI:       if (stat_i.tri_more && !stat_i.indexed) cmd_o.op = OP_SEQ_V;
      ST_IDX:       cmd_o.op = OP_IDX_RD;
      ST_CHECK:     if (stat_i.vfault) cmd_o.op = OP_SKIP;
      ST_POS:       cmd_o.op = OP_POS_RD;
      ST_EDGE:      cmd_o.op = OP_EDGE;
      ST_MUL:       cmd_o.op = OP_MUL;
      ST_SRD:       cmd_o.op = OP_SUM_RD;
      ST_SWR:       cmd_o.op = OP_SUM_WR;
      ST_NEXT:      cmd_o.op = OP_NEXT;
      ST_DONE:      cmd_o.op = OP_EMIT_DONE;
      ST_RSEL:      if (!stat_i.slot_oob) cmd_o.op = OP_RD_SLOT;
      ST_MAG:       cmd_o.op = OP_MAG;
      ST_SHIFT:     if (!stat_i.zero && stat_i.big) cmd_o.op = OP_SHIFT;
      ST_SQ:        cmd_o.op = OP_SQ;
      ST_SQRT_INIT: cmd_o.op = OP_SQRT_INIT;
      ST_SQRT:      if (stat_i.sqrt_busy) cmd_o.op = OP_SQRT_STEP;
      ST_DIV_INIT:  cmd_o.op = OP_DIV_INIT;
      ST_DIV:       cmd_o.op = OP_DIV_STEP;
      ST_DIV_END:   cmd_o.op = OP_DIV_END;
      ST_EMIT:      cmd_o.op = OP_EMIT_RD;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* rtl/core/vna_dp.sv */
module vna_dp import vna_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vna_in_t               in_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  vna_cmd_t              cmd_i,
  output vna_stat_t             stat_o,
  output vna_out_t              result_o,
  output logic                  result_valid_o
);

  // memories
  logic [47:0]           pos_mem [MAX_VERTICES];
  logic [VA_W-1:0]       idx_mem [MAX_INDICES];
  logic [2:0][SUM_W-1:0] sum_mem [MAX_VERTICES];

  logic [VC_W-1:0] vcnt_q;
  logic [IC_W-1:0] icnt_q;
  vna_in_t         in_q;

  logic [VA_W-1:0]       clr_cnt_q;
  logic [IC_W-1:0]       ptr_q;
  logic                  fault_q;
  logic [VA_W-1:0]       v_q [3];
  logic [47:0]           pos_rd_q;
  logic [VA_W-1:0]       idx_rd_q;
  logic [2:0][SUM_W-1:0] sum_rd_q;
  logic signed [15:0]    p_q [3][3];
  logic signed [16:0]    e1_q [3];
  logic signed [16:0]    e2_q [3];
  logic signed [61:0]    prod_q;
  logic signed [CR_W-1:0] cr_q [3];

  logic [SUM_W-1:0]  mag_q [3];
  logic [2:0]        neg_q;
  logic [61:0]       sq_q;
  logic [62:0]       rem_q, res_q, bit_q;
  logic [31:0]       drem_q;
  logic [15:0]       dlow_q, quo_q;
  logic [3:0]        dcnt_q;
  logic signed [15:0] n_q [3];

  vna_out_t res_out_q;
  logic     res_vld_q;

  // effective counts
  logic [VC_W-1:0] vc_eff;
  logic [IC_W-1:0] ic_eff, limit;
  assign vc_eff = (vcnt_q > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vcnt_q;
  assign ic_eff = (icnt_q > IC_W'(MAX_INDICES)) ? IC_W'(MAX_INDICES) : icnt_q;
  assign limit  = (ic_eff != '0) ? ic_eff : IC_W'(vc_eff);

  logic [1:0] ln;
  assign ln = cmd_i.lane[1:0];

  // multiplier operand select, one product a cycle
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod_full;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == OP_MUL) begin
      case (cmd_i.lane)
        3'd0: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[2]); end
        3'd1: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[1]); end
        3'd2: begin mul_a = 31'(e1_q[2]); mul_b = 31'(e2_q[0]); end
        3'd3: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[2]); end
        3'd4: begin mul_a = 31'(e1_q[0]); mul_b = 31'(e2_q[1]); end
        3'd5: begin mul_a = 31'(e1_q[1]); mul_b = 31'(e2_q[0]); end
        default: ;
      endcase
    end else if (cmd_i.op == OP_SQ && cmd_i.lane < 3'd3) begin
      mul_a = $signed({1'b0, mag_q[ln][29:0]});
      mul_b = $signed({1'b0, mag_q[ln][29:0]});
    end
  end
  assign prod_full = mul_a * mul_b;

  // saturating accumulate
  logic [SUM_W-1:0] sat_sum [3];
  always_comb begin
    logic signed [SUM_W:0] s;
    for (int c = 0; c < 3; c++) begin
      s = $signed({sum_rd_q[c][SUM_W-1], sum_rd_q[c]}) + (SUM_W+1)'(cr_q[c]);
      if (s[SUM_W] != s[SUM_W-1])
        sat_sum[c] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      else
        sat_sum[c] = s[SUM_W-1:0];
    end
  end

  // divider numerator and step
  logic [31:0] root;
  logic [45:0] num;
  logic [32:0] drem2;
  assign root  = res_q[31:0];
  assign num   = {1'b0, mag_q[ln][29:0], 15'b0} + 46'(root[31:1]);
  assign drem2 = {drem_q, dlow_q[15]};

  // sqrt step
  logic [62:0] sq_try;
  assign sq_try = res_q + bit_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
      icnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTEX_COUNT: vcnt_q <= cfg_wdata_i[VC_W-1:0];
        CFG_INDEX_COUNT:  icnt_q <= cfg_wdata_i[IC_W-1:0];
        default: ;
      endcase
    end
  end

  // position store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT && in_i.func == FUNC_WR_POS && in_i.slot[11:VA_W] == '0)
      pos_mem[in_i.slot[VA_W-1:0]] <= {in_i.pos_z, in_i.pos_y, in_i.pos_x};
    if (cmd_i.op == OP_POS_RD)
      pos_rd_q <= pos_mem[v_q[ln]];
  end

  // index store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ACCEPT && in_i.func == FUNC_WR_IDX)
      idx_mem[in_i.slot[IA_W-1:0]] <= in_i.index_value;
    if (cmd_i.op == OP_IDX_RD)
      idx_rd_q <= idx_mem[IA_W'(ptr_q + IC_W'(ln))];
  end

  // accumulator store
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_CLR)
      sum_mem[clr_cnt_q] <= '0;
    else if (cmd_i.op == OP_SUM_WR)
      sum_mem[v_q[ln]] <= {sat_sum[2], sat_sum[1], sat_sum[0]};
    if (cmd_i.op == OP_SUM_RD)
      sum_rd_q <= sum_mem[v_q[ln]];
    else if (cmd_i.op == OP_RD_SLOT)
      sum_rd_q <= sum_mem[in_q.slot[VA_W-1:0]];
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (cmd_i.op == OP_EMIT_DONE) || (cmd_i.op == OP_EMIT_RD);
      if (cmd_i.op == OP_CLR) clr_cnt_q <= clr_cnt_q + VA_W'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        in_q <= in_i;
        for (int c = 0; c < 3; c++) n_q[c] <= '0;
      end
      OP_TRI_INIT: begin
        ptr_q   <= '0;
        fault_q <= 1'b0;
      end
      OP_SEQ_V: for (int k = 0; k < 3; k++) v_q[k] <= VA_W'(ptr_q + IC_W'(k));
      OP_IDX_RD: if (ln != 2'd0) v_q[ln - 2'd1] <= idx_rd_q;
      OP_SKIP: begin
        fault_q <= 1'b1;
        ptr_q   <= ptr_q + IC_W'(3);
      end
      OP_POS_RD: if (ln != 2'd0) begin
        p_q[ln - 2'd1][0] <= pos_rd_q[15:0];
        p_q[ln - 2'd1][1] <= pos_rd_q[31:16];
        p_q[ln - 2'd1][2] <= pos_rd_q[47:32];
      end
      OP_EDGE: for (int k = 0; k < 3; k++) begin
        e1_q[k] <= 17'(p_q[1][k]) - 17'(p_q[0][k]);
        e2_q[k] <= 17'(p_q[2][k]) - 17'(p_q[0][k]);
      end
      OP_MUL: begin
        prod_q <= prod_full;
        if (cmd_i.lane != 3'd0) begin
          if (cmd_i.lane[0]) cr_q[cmd_i.lane[2:1]] <= prod_q[CR_W-1:0];
          else cr_q[cmd_i.lane[2:1] - 2'd1] <=
                 cr_q[cmd_i.lane[2:1] - 2'd1] - prod_q[CR_W-1:0];
        end
      end
      OP_NEXT: ptr_q <= ptr_q + IC_W'(3);
      OP_MAG: for (int c = 0; c < 3; c++) begin
        neg_q[c] <= sum_rd_q[c][SUM_W-1];
        mag_q[c] <= sum_rd_q[c][SUM_W-1] ? (SUM_W'(0) - sum_rd_q[c]) : sum_rd_q[c];
      end
      OP_SHIFT: for (int c = 0; c < 3; c++) mag_q[c] <= mag_q[c] >> 1;
      OP_SQ: begin
        prod_q <= prod_full;
        if (cmd_i.lane == 3'd0) sq_q <= '0;
        else                    sq_q <= sq_q + prod_q;
      end
      OP_SQRT_INIT: begin
        rem_q <= 63'(sq_q);
        res_q <= '0;
        bit_q <= 63'(1) << 62;
      end
      OP_SQRT_STEP: begin
        if (rem_q >= sq_try) begin
          rem_q <= rem_q - sq_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_DIV_INIT: begin
        drem_q <= 32'(num[45:16]);
        dlow_q <= num[15:0];
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      OP_DIV_STEP: begin
        if (drem2 >= {1'b0, root}) begin
          drem_q <= 32'(drem2 - {1'b0, root});
          quo_q  <= {quo_q[14:0], 1'b1};
        end else begin
          drem_q <= drem2[31:0];
          quo_q  <= {quo_q[14:0], 1'b0};
        end
        dlow_q <= {dlow_q[14:0], 1'b0};
        dcnt_q <= dcnt_q + 4'd1;
      end
      OP_DIV_END: begin
        logic [15:0] nm;
        nm = quo_q[15] ? 16'd32767 : quo_q;
        n_q[ln] <= neg_q[ln] ? $signed(16'd0 - nm) : $signed(nm);
      end
      OP_EMIT_DONE: begin
        res_out_q             <= '0;
        res_out_q.is_done     <= 1'b1;
        res_out_q.index_fault <= fault_q;
      end
      OP_EMIT_RD: begin
        res_out_q.vertex_slot <= in_q.slot[9:0];
        res_out_q.normal_x    <= n_q[0];
        res_out_q.normal_y    <= n_q[1];
        res_out_q.normal_z    <= n_q[2];
        res_out_q.is_done     <= 1'b0;
        res_out_q.index_fault <= 1'b0;
      end
      default: ;
    endcase
  end

  // status to controller
  assign stat_o.clr_last  = &clr_cnt_q;
  assign stat_o.tri_more  = (14'(ptr_q) + 14'd3) <= 14'(limit);
  assign stat_o.indexed   = (ic_eff != '0);
  assign stat_o.vfault    = (VC_W'(v_q[0]) >= vc_eff) || (VC_W'(v_q[1]) >= vc_eff) ||
                            (VC_W'(v_q[2]) >= vc_eff);
  assign stat_o.slot_oob  = (in_q.slot[11:VA_W] != '0);
  assign stat_o.zero      = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign stat_o.big       = |{mag_q[0][SUM_W-1:30], mag_q[1][SUM_W-1:30],
                              mag_q[2][SUM_W-1:30]};
  assign stat_o.sqrt_busy = |bit_q;
  assign stat_o.div_last  = &dcnt_q;

  assign result_o       = res_out_q;
  assign result_valid_o = res_vld_q;

endmodule

/* rtl/core/vertex_normal_accumulate.sv */
// Loads are taken while idle and leave busy low. A read's delay after acceptance is set by
// the magnitude shift, the square root and three divides; a zero sum answers sooner and a
// slot outside the store sooner still. A compute first clears every accumulator, then
// works through each triangle (longer when indexed, shorter for a skipped one) and
// finishes, with busy high throughout. After reset busy is high while the accumulators
// clear; no stall.
module vertex_normal_accumulate import vna_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  vna_in_t               in_i,
  output vna_out_t              result_o,
  output logic                  result_valid_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  vna_cmd_t  cmd;
  vna_stat_t stat;

  // sequencer
  vna_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .func_i (in_i.func),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // stores, arithmetic and result register
  vna_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule
